// ===== rtl/core/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter package
// Shared constants, types and sector codes for the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  // Hue units in one 60-degree sector (degrees times 64).
  localparam int unsigned SectorUnits = 3840;
  // Full scale of saturation and value.
  localparam int unsigned FullScale   = 255;
  // Highest sector number that a 15-bit hue can reach.
  localparam int unsigned MaxSector   = 8;

  // Denominator of every helper level: 255 * 3840.
  localparam logic [19:0] LevelDen = 20'(FullScale * SectorUnits);
  // The denominator splits into 256 * 3825; the 256 is a plain shift.
  localparam int unsigned DivShift  = 8;
  localparam int unsigned LevelDiv  = (FullScale * SectorUnits) / 256;
  // Reciprocal of 3825 scaled by 2^24, rounded down.
  localparam int unsigned RecipShift = 24;
  localparam int unsigned LevelRecip = (2 ** RecipShift) / LevelDiv;

  // Sector codes; every code above the magenta sector uses its ordering.
  localparam logic [3:0] SecRed     = 4'd0;
  localparam logic [3:0] SecYellow  = 4'd1;
  localparam logic [3:0] SecGreen   = 4'd2;
  localparam logic [3:0] SecCyan    = 4'd3;
  localparam logic [3:0] SecBlue    = 4'd4;
  localparam logic [3:0] SecMagenta = 4'd5;

  typedef logic [3:0]  sector_t;
  typedef logic [11:0] frac_t;   // position inside a sector, 0..3839
  typedef logic [12:0] fpart_t;  // fraction operand of a level, 0..3840
  typedef logic [7:0]  level_t;

  // Side information that travels alongside the level lanes.
  typedef struct packed {
    logic [9:0] idx;
    logic       grey;
    level_t     v;
    sector_t    sector;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsvrgb_ifs.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter channels
// Valid/ready channels for the HSV input words and the RGB result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  led_index;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  value;

  modport source (output valid, output led_index, output hue,
                  output saturation, output value, input ready);
  modport sink   (input valid, input led_index, input hue,
                  input saturation, input value, output ready);
endinterface

interface hsvrgb_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] led_out_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output led_out_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input led_out_index, input red,
                  input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsvrgb_split.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter, sector split stage
// Splits the hue into a sector number and an offset inside the sector, and
// registers them with the rest of the word.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_split import hsvrgb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [9:0]  led_index,
  input  logic [14:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  value,
  output ctrl_t       ctrl,
  output logic [7:0]  sat,
  output frac_t       frac
);

  sector_t     sector_w;
  logic [14:0] base_w;
  frac_t       frac_w;

  // Compare against every sector boundary in parallel; the highest one passed wins.
  always_comb begin
    sector_w = '0;
    base_w   = '0;
    for (int k = 1; k <= MaxSector; k++) begin
      if (hue >= 15'(k * SectorUnits)) begin
        sector_w = 4'(k);
        base_w   = 15'(k * SectorUnits);
      end
    end
    frac_w = 12'(hue - base_w);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      ctrl.idx    <= led_index;
      ctrl.grey   <= (saturation == 8'd0);
      ctrl.v      <= value;
      ctrl.sector <= sector_w;
      sat         <= saturation;
      frac        <= frac_w;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsvrgb_level.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter, helper level lane
// Four-stage lane that computes floor(v * (979200 - s * f) / 979200).
// The division is a shift by 256 followed by a reciprocal multiply by 1/3825
// with one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_level import hsvrgb_pkg::*; (
  input  logic       clk,
  input  logic [3:0] en,
  input  logic [7:0] s,
  input  level_t     v,
  input  fpart_t     fpart,
  output level_t     level
);

  logic [19:0] prod_w;
  logic [19:0] prod_a;
  level_t      v_a;
  logic [19:0] diff_w;
  logic [27:0] num_w;
  logic [19:0] y_b;
  logic [31:0] recip_w;
  logic [19:0] y_c;
  level_t      est_c;
  logic [19:0] back_w;
  logic [19:0] rem_w;

  // Stage A: saturation times the fraction operand.
  assign prod_w = 20'({13'd0, s} * {8'd0, fpart});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_a <= prod_w;
      v_a    <= v;
    end
  end

  // Stage B: value times the remaining weight, pre-divided by 256.
  assign diff_w = LevelDen - prod_a;
  assign num_w  = {20'd0, v_a} * {8'd0, diff_w};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y_b <= num_w[27:DivShift];
    end
  end

  // Stage C: quotient estimate by reciprocal multiply, never too high.
  assign recip_w = {12'd0, y_b} * 32'(LevelRecip);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y_c   <= y_b;
      est_c <= recip_w[RecipShift +: 8];
    end
  end

  // Stage D: the estimate is at most one short; fix it from the remainder.
  assign back_w = {12'd0, est_c} * 20'(LevelDiv);
  assign rem_w  = y_c - back_w;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      level <= (rem_w >= 20'(LevelDiv)) ? est_c + 8'd1 : est_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_led_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter
// Top level: sector split, three helper level lanes, sector ordering and the
// output register, with valid bits and per-stage stall control.
// ----------------------------------------------------------------------------
// Takes one HSV word per clock while hsv.ready is high and returns one RGB word
// per input word, in order, with the LED index carried through. The pipeline
// is six register stages deep. Each stage holds its word only while the stage
// after it is full and stalled, so bubbles close up under backpressure and the
// input keeps taking words while any stage ahead of it is empty. Saturation
// zero gives grey; hues of 360 degrees and above use the magenta sector
// ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_led_unit import hsvrgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hsvrgb_in_if.sink     hsv,
  hsvrgb_out_if.source  rgb
);

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;

  ctrl_t       ctrl0;
  logic [7:0]  sat0;
  frac_t       frac0;
  ctrl_t       ctrl_q [1:4];
  level_t      lvl_p;
  level_t      lvl_q;
  level_t      lvl_t;
  fpart_t      fp_p;
  fpart_t      fp_q;
  fpart_t      fp_t;
  level_t      red_w;
  level_t      green_w;
  level_t      blue_w;
  logic [9:0]  idx_out;
  level_t      red_out;
  level_t      green_out;
  level_t      blue_out;

  // A stage may load when it is empty or when its word moves on.
  always_comb begin
    en[Stages-1] = !vld[Stages-1] || rgb.ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign hsv.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsv.valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: sector split.
  hsvrgb_split u_split (
    .clk        (clk),
    .en         (en[0]),
    .led_index  (hsv.led_index),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .value      (hsv.value),
    .ctrl       (ctrl0),
    .sat        (sat0),
    .frac       (frac0)
  );

  // Fraction operands of the three levels: Q uses the offset, T its
  // complement, and P a full sector, which reduces to v * (255 - s) / 255.
  assign fp_q = {1'b0, frac0};
  assign fp_t = 13'(SectorUnits) - {1'b0, frac0};
  assign fp_p = 13'(SectorUnits);

  // Stages 2 to 5: the three level lanes.
  hsvrgb_level u_level_p (
    .clk   (clk),
    .en    (en[4:1]),
    .s     (sat0),
    .v     (ctrl0.v),
    .fpart (fp_p),
    .level (lvl_p)
  );

  hsvrgb_level u_level_q (
    .clk   (clk),
    .en    (en[4:1]),
    .s     (sat0),
    .v     (ctrl0.v),
    .fpart (fp_q),
    .level (lvl_q)
  );

  hsvrgb_level u_level_t (
    .clk   (clk),
    .en    (en[4:1]),
    .s     (sat0),
    .v     (ctrl0.v),
    .fpart (fp_t),
    .level (lvl_t)
  );

  // Side information follows the lanes stage by stage.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctrl_q[1] <= ctrl0;
    end
    for (int i = 2; i <= 4; i++) begin
      if (en[i]) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  // Order the levels by sector; grey overrides everything.
  always_comb begin
    case (ctrl_q[4].sector)
      SecRed: begin
        red_w = ctrl_q[4].v; green_w = lvl_t; blue_w = lvl_p;
      end
      SecYellow: begin
        red_w = lvl_q; green_w = ctrl_q[4].v; blue_w = lvl_p;
      end
      SecGreen: begin
        red_w = lvl_p; green_w = ctrl_q[4].v; blue_w = lvl_t;
      end
      SecCyan: begin
        red_w = lvl_p; green_w = lvl_q; blue_w = ctrl_q[4].v;
      end
      SecBlue: begin
        red_w = lvl_t; green_w = lvl_p; blue_w = ctrl_q[4].v;
      end
      default: begin
        red_w = ctrl_q[4].v; green_w = lvl_p; blue_w = lvl_q;
      end
    endcase
    if (ctrl_q[4].grey) begin
      red_w   = ctrl_q[4].v;
      green_w = ctrl_q[4].v;
      blue_w  = ctrl_q[4].v;
    end
  end

  // Stage 6: output register.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      idx_out   <= ctrl_q[4].idx;
      red_out   <= red_w;
      green_out <= green_w;
      blue_out  <= blue_w;
    end
  end

  assign rgb.valid         = vld[Stages-1];
  assign rgb.led_out_index = idx_out;
  assign rgb.red           = red_out;
  assign rgb.green         = green_out;
  assign rgb.blue          = blue_out;

endmodule

`default_nettype wire

// ===== rtl/core/hsvrgb_check.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter checker
// Port-level checks on output handshake and word count, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [9:0] out_index,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  localparam int unsigned Depth = 6;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count of words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("result payload changed while stalled");

  // No result word appears without a matching input word.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 4'd0)
    else $error("result word without a pending input word");

  // The pipeline never holds more words than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(Depth))
    else $error("more words in flight than pipeline stages");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind hsv_to_rgb_led_unit hsvrgb_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .out_index (rgb.led_out_index),
  .out_red   (rgb.red),
  .out_green (rgb.green),
  .out_blue  (rgb.blue)
);

`default_nettype wire

// ===== test/hsv_to_rgb_led_unit_tb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB LED converter testbench
// Sends HSV words with LED indexes through the converter. Each accepted word
// is converted by an independent fixed-point colour calculation, and every
// RGB word that comes back is compared with the oldest pending colour. Both
// handshake sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_led_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;

  // One HSV word to send; drain_first holds it back until all colours are in.
  typedef struct {
    logic [9:0]  idx;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        drain_first;
  } hsv_word_t;

  // One RGB word as it should come back.
  typedef struct {
    logic [9:0] idx;
    level_t     red;
    level_t     green;
    level_t     blue;
  } rgb_word_t;

  logic clk;
  logic rst;

  hsvrgb_in_if  hsv_ch ();
  hsvrgb_out_if rgb_ch ();

  hsv_to_rgb_led_unit i_dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  hsv_word_t   words_to_send[$];
  rgb_word_t   colors_due[$];
  hsv_word_t   word_on_bus;
  int unsigned faults;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned send_cycles;
  int unsigned recv_cycles;
  logic        calm;

  // Clock generation.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Near the end of the run neither side idles.
  assign calm = (words_to_send.size() < 100);

  // Blend level floor(v * (255*3840 - s*fp) / (255*3840)).
  function automatic int unsigned blend_level(int unsigned v, int unsigned s,
                                              int unsigned fp);
    int unsigned den;
    den = FullScale * SectorUnits;
    return (v * (den - s * fp)) / den;
  endfunction

  // Expected colour of one HSV word.
  function automatic rgb_word_t convert_hsv(hsv_word_t w);
    rgb_word_t   c;
    int unsigned v;
    int unsigned s;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sec;
    v = w.val;
    s = w.sat;
    c.idx = w.idx;
    if (s == 0) begin
      c.red = level_t'(v);
      c.green = level_t'(v);
      c.blue = level_t'(v);
    end else begin
      sec = sector_t'(int'(w.hue) / SectorUnits);
      frac = int'(w.hue) % SectorUnits;
      p = (v * (FullScale - s)) / FullScale;
      q = blend_level(v, s, frac);
      t = blend_level(v, s, SectorUnits - frac);
      case (sec)
        SecRed: begin
          c.red = level_t'(v); c.green = level_t'(t); c.blue = level_t'(p);
        end
        SecYellow: begin
          c.red = level_t'(q); c.green = level_t'(v); c.blue = level_t'(p);
        end
        SecGreen: begin
          c.red = level_t'(p); c.green = level_t'(v); c.blue = level_t'(t);
        end
        SecCyan: begin
          c.red = level_t'(p); c.green = level_t'(q); c.blue = level_t'(v);
        end
        SecBlue: begin
          c.red = level_t'(t); c.green = level_t'(p); c.blue = level_t'(v);
        end
        // Magenta ordering, also used for hues of 360 degrees and above.
        default: begin
          c.red = level_t'(v); c.green = level_t'(p); c.blue = level_t'(q);
        end
      endcase
    end
    return c;
  endfunction

  task automatic queue_word(int unsigned idx, int unsigned hue, int unsigned sat,
                            int unsigned val, bit drain);
    hsv_word_t w;
    w.idx = 10'(idx);
    w.hue = 15'(hue);
    w.sat = 8'(sat);
    w.val = 8'(val);
    w.drain_first = drain;
    words_to_send.push_back(w);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      faults++;
    end
  endtask

  // Driver: presents queued words on the HSV channel.
  always @(posedge clk) begin
    if (rst) begin
      hsv_ch.valid <= 1'b0;
      gap_left = 0;
      send_cycles = 0;
      send_idle_pct = 20;
    end else begin
      if (hsv_ch.valid && hsv_ch.ready) begin
        colors_due.push_back(convert_hsv(word_on_bus));
      end
      send_cycles++;
      if (send_cycles % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
      end
      if (hsv_ch.valid && !hsv_ch.ready) begin
        // The word on the bus stays until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        hsv_ch.valid <= 1'b0;
      end else if (words_to_send.size() == 0) begin
        hsv_ch.valid <= 1'b0;
      end else if (words_to_send[0].drain_first && colors_due.size() != 0) begin
        hsv_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
        gap_left = $urandom_range(1, 8) - 1;
        hsv_ch.valid <= 1'b0;
      end else begin
        word_on_bus = words_to_send.pop_front();
        hsv_ch.valid <= 1'b1;
        hsv_ch.led_index <= word_on_bus.idx;
        hsv_ch.hue <= word_on_bus.hue;
        hsv_ch.saturation <= word_on_bus.sat;
        hsv_ch.value <= word_on_bus.val;
      end
    end
  end

  // Monitor: compares each RGB word and drives ready with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      rgb_ch.ready <= 1'b0;
      stall_left = 0;
      recv_cycles = 0;
      recv_idle_pct = 20;
    end else begin
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (colors_due.size() == 0) begin
          $display("%0t ns: no colour expected, got index %0d rgb %0d %0d %0d", $time,
                   rgb_ch.led_out_index, rgb_ch.red, rgb_ch.green, rgb_ch.blue);
          faults++;
        end else begin
          rgb_word_t want;
          want = colors_due.pop_front();
          check_field("led_out_index", want.idx, rgb_ch.led_out_index);
          check_field("red", want.red, rgb_ch.red);
          check_field("green", want.green, rgb_ch.green);
          check_field("blue", want.blue, rgb_ch.blue);
        end
      end
      recv_cycles++;
      if (recv_cycles % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 15;
          default: recv_idle_pct = 40;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        rgb_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 8) - 1;
        rgb_ch.ready <= 1'b0;
      end else begin
        rgb_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned mode;
    int unsigned hue;
    int unsigned sat;
    int unsigned val;
    faults = 0;
    rst = 1'b1;
    hsv_ch.valid = 1'b0;
    hsv_ch.led_index = '0;
    hsv_ch.hue = '0;
    hsv_ch.saturation = '0;
    hsv_ch.value = '0;
    rgb_ch.ready = 1'b0;

    // Directed words: field extremes, every sector, grey and out-of-range hues.
    queue_word(0, 0, 0, 0, 1'b0);
    queue_word(1023, 0, 255, 255, 1'b0);
    queue_word(1, 0, 0, 200, 1'b0);
    queue_word(2, 12345, 0, 77, 1'b0);
    queue_word(3, 1920, 255, 255, 1'b0);
    queue_word(4, 3839, 255, 255, 1'b0);
    queue_word(5, 3840, 255, 255, 1'b0);
    queue_word(6, 5760, 200, 180, 1'b0);
    queue_word(7, 7680, 128, 255, 1'b0);
    queue_word(8, 9600, 255, 100, 1'b0);
    queue_word(9, 11520, 1, 255, 1'b0);
    queue_word(10, 13440, 255, 1, 1'b0);
    queue_word(11, 15360, 90, 240, 1'b0);
    queue_word(12, 17280, 255, 255, 1'b0);
    queue_word(13, 19200, 170, 210, 1'b0);
    queue_word(14, 21120, 255, 128, 1'b0);
    queue_word(15, 23039, 255, 255, 1'b0);
    queue_word(16, 23040, 255, 255, 1'b0);
    queue_word(17, 26880, 140, 220, 1'b0);
    queue_word(18, 30720, 255, 255, 1'b0);
    queue_word(19, 32767, 255, 255, 1'b0);
    queue_word(20, 32767, 0, 255, 1'b0);
    queue_word(682, 10922, 85, 170, 1'b0);
    queue_word(341, 21845, 170, 85, 1'b0);

    // Random words, mostly in-range hues; two points wait for a full drain.
    for (int n = 0; n < 1050; n++) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) hue = $urandom_range(0, 23039);
      else if (mode < 80) hue = $urandom_range(0, 5) * SectorUnits +
                                ($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                      : SectorUnits - 1);
      else if (mode < 88) hue = $urandom_range(23040, 32767);
      else hue = $urandom_range(0, 32767);
      mode = $urandom_range(0, 99);
      if (mode < 10) sat = 0;
      else if (mode < 20) sat = 255;
      else if (mode < 25) sat = 1;
      else sat = $urandom_range(0, 255);
      mode = $urandom_range(0, 99);
      if (mode < 8) val = 0;
      else if (mode < 16) val = 255;
      else val = $urandom_range(0, 255);
      queue_word($urandom_range(0, 1023), hue, sat, val, (n == 0) || (n == 500));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every colour to come back.
    do begin
      @(posedge clk);
    end while (words_to_send.size() != 0 || hsv_ch.valid || colors_due.size() != 0);
    repeat (20) @(posedge clk);

    if (faults == 0 && colors_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_ifs.sv
rtl/core/hsvrgb_split.sv
rtl/core/hsvrgb_level.sv
rtl/core/hsv_to_rgb_led_unit.sv
rtl/core/hsvrgb_check.sv
test/hsv_to_rgb_led_unit_tb.sv
